// ===== hw/rtl/contiguous_fit_allocator_unit_defines.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_UNIT_DEFINES_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cfa_pkg.sv =====
package cfa_pkg;

    localparam int unsigned SIZE_W  = 31;
    localparam int unsigned OUT_IDX_W = 6;
    localparam int unsigned COUNT_W = 32;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_REQUEST = 2'd1;
    localparam logic [1:0] MODE_RESTORE = 2'd2;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [SIZE_W-1:0] size_value;
    } t_in_req;

    typedef struct packed {
        logic                 granted;
        logic [OUT_IDX_W-1:0] block_index;
        logic [COUNT_W-1:0]   request_number;
        logic [COUNT_W-1:0]   granted_total;
    } t_out_rsp;

    typedef struct packed {
        logic load;
        logic req_start;
        logic rst_start;
        logic rd_issue;
        logic rd_restore;
        logic finish;
    } t_cfa_cmd;

    typedef struct packed {
        logic loaded_zero;
        logic addr_last;
        logic out_free;
    } t_cfa_status;

endpackage

// ===== hw/rtl/cfa_ram.sv =====
module cfa_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/cfa_ctrl.sv =====
`include "contiguous_fit_allocator_unit_defines.svh"

module cfa_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_mode,
    output logic                 o_in_stall,
    input  cfa_pkg::t_cfa_status i_status,
    output cfa_pkg::t_cfa_cmd    o_cmd
);
    import cfa_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SCAN      = 3'd1;
    localparam logic [2:0] ST_LAST      = 3'd2;
    localparam logic [2:0] ST_WB        = 3'd3;
    localparam logic [2:0] ST_REST      = 3'd4;
    localparam logic [2:0] ST_REST_LAST = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cfa_cmd   w_cmd;
    logic       w_accept;

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_mode)
                        MODE_LOAD: begin
                            w_cmd.load = 1'b1;
                        end
                        MODE_REQUEST: begin
                            w_cmd.req_start = 1'b1;
                            n_state = i_status.loaded_zero ? ST_WB : ST_SCAN;
                        end
                        MODE_RESTORE: begin
                            w_cmd.rst_start = 1'b1;
                            n_state = i_status.loaded_zero ? ST_IDLE : ST_REST;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                w_cmd.rd_issue = 1'b1;
                if (i_status.addr_last) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_WB;
            end
            ST_WB: begin
                if (i_status.out_free) begin
                    w_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_REST: begin
                w_cmd.rd_issue   = 1'b1;
                w_cmd.rd_restore = 1'b1;
                if (i_status.addr_last) begin
                    n_state = ST_REST_LAST;
                end
            end
            ST_REST_LAST: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = w_cmd;

    `CFA_ASSERT_NEXT(a_req_leaves_idle, i_clk, i_rst_n,
        w_accept && (i_mode == MODE_REQUEST), r_state != ST_IDLE, "request did not start")
    `CFA_ASSERT_NOW(a_finish_only_free, i_clk, i_rst_n,
        w_cmd.finish, i_status.out_free, "result emitted into a full output register")

endmodule

// ===== hw/rtl/cfa_datapath.sv =====
`include "contiguous_fit_allocator_unit_defines.svh"

module cfa_datapath #(
    parameter int unsigned MAX_BLOCKS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cfa_pkg::t_in_req     i_in_data,
    input  logic [1:0]           i_cfg_wdata,
    input  logic                 i_cfg_we,
    input  cfa_pkg::t_cfa_cmd    i_cmd,
    output cfa_pkg::t_cfa_status o_status,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output cfa_pkg::t_out_rsp    o_out_data
);
    import cfa_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_BLOCKS > 1 ? MAX_BLOCKS : 2);
    localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

    logic [1:0]         r_policy;
    logic [CNT_W-1:0]   r_loaded;
    logic [CNT_W-1:0]   r_addr;
    logic               r_rd_vld;
    logic               r_rd_rest;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [SIZE_W-1:0]  r_req;
    logic               r_found;
    logic [IDX_W-1:0]   r_best_idx;
    logic [SIZE_W-1:0]  r_best_have;
    logic [COUNT_W-1:0] r_req_cnt;
    logic [COUNT_W-1:0] r_grant_cnt;
    logic               r_out_valid;
    t_out_rsp           r_out_data;

    logic [SIZE_W-1:0]     w_orig_rdata;
    logic [SIZE_W-1:0]     w_rem_rdata;
    logic                  w_full;
    logic                  w_load_wr;
    logic                  w_rem_we;
    logic [IDX_W-1:0]      w_rem_waddr;
    logic [SIZE_W-1:0]     w_rem_wdata;
    logic                  w_eval;
    logic                  w_fits;
    logic                  w_take;
    logic [IDX_W+5:0]      w_idx_ext;
    logic                  w_out_free;

    assign w_full     = (r_loaded == CNT_W'(MAX_BLOCKS));
    assign w_load_wr  = i_cmd.load && !w_full;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_rem_we    = 1'b0;
        w_rem_waddr = r_loaded[IDX_W-1:0];
        w_rem_wdata = i_in_data.size_value;
        priority if (r_rd_vld && r_rd_rest) begin
            w_rem_we    = 1'b1;
            w_rem_waddr = r_rd_idx;
            w_rem_wdata = w_orig_rdata;
        end else if (i_cmd.finish && r_found) begin
            w_rem_we    = 1'b1;
            w_rem_waddr = r_best_idx;
            w_rem_wdata = r_best_have - r_req;
        end else if (w_load_wr) begin
            w_rem_we = 1'b1;
        end
    end

    cfa_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_BLOCKS)) u_orig_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_wr),
        .i_waddr (r_loaded[IDX_W-1:0]),
        .i_wdata (i_in_data.size_value),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (w_orig_rdata)
    );

    cfa_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_BLOCKS)) u_rem_ram (
        .i_clk   (i_clk),
        .i_we    (w_rem_we),
        .i_waddr (w_rem_waddr),
        .i_wdata (w_rem_wdata),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (w_rem_rdata)
    );

    // Leftover order equals remaining-size order for a fixed request size.
    assign w_eval = r_rd_vld && !r_rd_rest;
    assign w_fits = (w_rem_rdata >= r_req);

    always_comb begin
        unique case (r_policy)
            POL_FIRST: w_take = w_fits && !r_found;
            POL_BEST:  w_take = w_fits && (!r_found || (w_rem_rdata < r_best_have));
            POL_WORST: w_take = w_fits && (!r_found || (w_rem_rdata > r_best_have));
            default:   w_take = 1'b0;
        endcase
    end

    assign w_idx_ext = {6'd0, r_best_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= POL_FIRST;
            r_loaded    <= '0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_rest   <= 1'b0;
            r_found     <= 1'b0;
            r_req_cnt   <= '0;
            r_grant_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
            if (w_load_wr) begin
                r_loaded <= r_loaded + CNT_W'(1);
            end
            r_rd_vld  <= i_cmd.rd_issue;
            r_rd_rest <= i_cmd.rd_restore;
            if (i_cmd.req_start || i_cmd.rst_start) begin
                r_addr <= '0;
            end else if (i_cmd.rd_issue) begin
                r_addr <= r_addr + CNT_W'(1);
            end
            if (i_cmd.req_start) begin
                r_found <= 1'b0;
            end else if (w_eval && w_take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.rst_start) begin
                r_req_cnt   <= '0;
                r_grant_cnt <= '0;
            end else if (i_cmd.finish) begin
                r_req_cnt   <= r_req_cnt + COUNT_W'(1);
                r_grant_cnt <= r_grant_cnt + COUNT_W'(r_found);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr[IDX_W-1:0];
        if (i_cmd.req_start) begin
            r_req <= i_in_data.size_value;
        end
        if (w_eval && w_take) begin
            r_best_idx  <= r_rd_idx;
            r_best_have <= w_rem_rdata;
        end
        if (i_cmd.finish) begin
            r_out_data.granted        <= r_found;
            r_out_data.block_index    <= r_found ? w_idx_ext[5:0] : '0;
            r_out_data.request_number <= r_req_cnt;
            r_out_data.granted_total  <= r_grant_cnt + COUNT_W'(r_found);
        end
    end

    assign o_status.loaded_zero = (r_loaded == '0);
    assign o_status.addr_last   = ((r_addr + CNT_W'(1)) == r_loaded);
    assign o_status.out_free    = w_out_free;
    assign o_out_valid          = r_out_valid;
    assign o_out_data           = r_out_data;

    `CFA_ASSERT_NOW(a_scan_in_range, i_clk, i_rst_n,
        i_cmd.rd_issue, r_addr < r_loaded, "read issued beyond loaded entries")
    `CFA_ASSERT_NOW(a_restore_write_alone, i_clk, i_rst_n,
        r_rd_vld && r_rd_rest, !i_cmd.finish && !i_cmd.load, "write port conflict")
    `CFA_ASSERT_NOW(a_out_rise_from_finish, i_clk, i_rst_n,
        $rose(r_out_valid), $past(i_cmd.finish), "result appeared without a finished request")

endmodule

// ===== hw/rtl/contiguous_fit_allocator_unit.sv =====
// Contiguous fit allocator over a table of up to MAX_BLOCKS free blocks.
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one request per
// handshake: load a block size, allocate a size, or restore original sizes.
// Output channel (o_out_valid / i_out_stall / o_out_data) returns one result
// per allocation: granted flag, block index, request number, grant total.
// i_cfg_we / i_cfg_wdata sets the fit policy: 0 first, 1 best, 2 worst fit.
// A load writes both RAMs unless the table is full. An allocation scans the
// N loaded entries one per cycle through the remaining-size RAM read port,
// then writes back the chosen entry and registers the result; the next
// request can be taken in the cycle in which the result appears. A restore
// copies the N entries from the original size RAM back into the
// remaining-size RAM. Loads and restores give no result.
// Reset empties the table, clears both counters and selects first fit.
// A stalled result stays in the output register; loads and restores still
// proceed behind it, while the next allocation waits at its write-back.
module contiguous_fit_allocator_unit #(
    parameter int unsigned MAX_BLOCKS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cfa_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cfa_pkg::t_out_rsp o_out_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_wdata
);
    import cfa_pkg::*;

    t_cfa_cmd    w_cmd;
    t_cfa_status w_status;

    cfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_data.mode),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cfa_datapath #(.MAX_BLOCKS(MAX_BLOCKS)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cfg_we    (i_cfg_we),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== tb/fit_alloc_checker.sv =====
module fit_alloc_checker #(
    parameter int unsigned MAX_BLOCKS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  cfa_pkg::t_in_req  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  cfa_pkg::t_out_rsp i_out_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_wdata,
    output int                o_fail_count,
    output int                o_pending
);
    import cfa_pkg::*;

    logic [SIZE_W-1:0]  orig_size [MAX_BLOCKS];
    logic [SIZE_W-1:0]  left_size [MAX_BLOCKS];
    int unsigned        n_loaded;
    logic [COUNT_W-1:0] req_count;
    logic [COUNT_W-1:0] grant_count;
    logic [1:0]         policy;
    t_out_rsp           pending_grants [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        n_loaded     = 0;
        req_count    = '0;
        grant_count  = '0;
        policy       = POL_FIRST;
    end

    // Scans loaded blocks in index order; ties keep the lowest index.
    function automatic t_out_rsp place_request(input logic [SIZE_W-1:0] need);
        t_out_rsp          r;
        logic              found;
        int unsigned       pick;
        int unsigned       j;
        logic [SIZE_W-1:0] spare;
        logic [SIZE_W-1:0] kept_spare;
        found      = 1'b0;
        pick       = 0;
        kept_spare = '0;
        for (j = 0; j < n_loaded; j++) begin
            if (left_size[j] >= need) begin
                spare = left_size[j] - need;
                case (policy)
                    POL_FIRST: begin
                        if (!found) begin
                            found = 1'b1;
                            pick  = j;
                        end
                    end
                    POL_BEST: begin
                        if (!found || spare < kept_spare) begin
                            found      = 1'b1;
                            pick       = j;
                            kept_spare = spare;
                        end
                    end
                    POL_WORST: begin
                        if (!found || spare > kept_spare) begin
                            found      = 1'b1;
                            pick       = j;
                            kept_spare = spare;
                        end
                    end
                    default: ;
                endcase
            end
        end
        r.granted        = found;
        r.block_index    = found ? pick[OUT_IDX_W-1:0] : '0;
        r.request_number = req_count;
        if (found) begin
            left_size[pick] = left_size[pick] - need;
            grant_count     = grant_count + 1'b1;
        end
        req_count       = req_count + 1'b1;
        r.granted_total = grant_count;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_rsp    want;
        int unsigned j;
        if (!i_rst_n) begin
            n_loaded    = 0;
            req_count   = '0;
            grant_count = '0;
            policy      = POL_FIRST;
            pending_grants.delete();
        end else begin
            if (i_cfg_we) begin
                policy = i_cfg_wdata;
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_grants.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("unexpected result: g=%0d idx=%0d n=%0d tot=%0d",
                            i_out_data.granted, i_out_data.block_index,
                            i_out_data.request_number, i_out_data.granted_total);
                    end
                end else begin
                    want = pending_grants.pop_front();
                    if (i_out_data.granted !== want.granted ||
                        i_out_data.block_index !== want.block_index ||
                        i_out_data.request_number !== want.request_number ||
                        i_out_data.granted_total !== want.granted_total) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display({"mismatch: exp g=%0d idx=%0d n=%0d tot=%0d",
                                " / got g=%0d idx=%0d n=%0d tot=%0d"},
                                want.granted, want.block_index,
                                want.request_number, want.granted_total,
                                i_out_data.granted, i_out_data.block_index,
                                i_out_data.request_number, i_out_data.granted_total);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_in_data.mode)
                    MODE_LOAD: begin
                        if (n_loaded < MAX_BLOCKS) begin
                            orig_size[n_loaded] = i_in_data.size_value;
                            left_size[n_loaded] = i_in_data.size_value;
                            n_loaded++;
                        end
                    end
                    MODE_REQUEST: begin
                        pending_grants.push_back(place_request(i_in_data.size_value));
                    end
                    MODE_RESTORE: begin
                        for (j = 0; j < n_loaded; j++) begin
                            left_size[j] = orig_size[j];
                        end
                        req_count   = '0;
                        grant_count = '0;
                    end
                    default: ;
                endcase
            end
        end
        o_pending = pending_grants.size();
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    import cfa_pkg::*;

    localparam int unsigned MAX_BLOCKS  = 64;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned N_PHASES    = 10;
    localparam int unsigned PHASE_ITEMS = 83;
    localparam int unsigned SETTLE      = MAX_BLOCKS + 8;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_in_req    i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_rsp   o_out_data;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_wdata = POL_FIRST;

    int          alloc_fails;
    int          alloc_pending;
    logic        quiet        = 1'b0;
    int unsigned loads_sent   = 0;
    int unsigned cycle_count  = 0;

    contiguous_fit_allocator_unit #(.MAX_BLOCKS(MAX_BLOCKS)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    fit_alloc_checker #(.MAX_BLOCKS(MAX_BLOCKS)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (alloc_fails),
        .o_pending    (alloc_pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 23);
    end

    task automatic put_request(input logic [1:0] mode, input logic [SIZE_W-1:0] size);
        t_in_req r;
        r.mode       = mode;
        r.size_value = size;
        while (!quiet && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        if (mode == MODE_LOAD) begin
            loads_sent++;
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (alloc_pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_policy(input logic [1:0] pol);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= pol;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_block_size();
        int unsigned r;
        logic [31:0] raw;
        r   = $urandom_range(99);
        raw = $urandom;
        if (r < 50) return SIZE_W'($urandom_range(1, 8) * 50);
        if (r < 80) return SIZE_W'($urandom_range(0, 1000));
        if (r < 90) return raw[SIZE_W-1:0];
        if (r < 95) return '0;
        return {SIZE_W{1'b1}};
    endfunction

    function automatic logic [SIZE_W-1:0] pick_need();
        int unsigned r;
        logic [31:0] raw;
        r   = $urandom_range(99);
        raw = $urandom;
        if (r < 40) return SIZE_W'($urandom_range(1, 8) * 25);
        if (r < 70) return SIZE_W'($urandom_range(0, 600));
        if (r < 80) return '0;
        if (r < 90) return raw[SIZE_W-1:0];
        return {SIZE_W{1'b1}} - SIZE_W'($urandom_range(0, 3));
    endfunction

    initial begin
        int unsigned ph;
        int unsigned k;
        int unsigned r;
        logic [31:0] raw;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, undefined mode, zero and full-scale blocks
        put_request(MODE_REQUEST, '0);
        put_request(MODE_RESTORE, '0);
        put_request(2'd3, {SIZE_W{1'b1}});
        put_request(MODE_LOAD, '0);
        put_request(MODE_LOAD, {SIZE_W{1'b1}});
        put_request(MODE_LOAD, SIZE_W'(100));
        put_request(MODE_LOAD, SIZE_W'(100));
        put_request(MODE_LOAD, SIZE_W'(300));
        put_request(MODE_REQUEST, '0);
        put_request(MODE_REQUEST, {SIZE_W{1'b1}});
        put_request(MODE_REQUEST, {SIZE_W{1'b1}});
        put_request(MODE_REQUEST, SIZE_W'(50));
        put_request(MODE_RESTORE, '0);

        set_policy(POL_BEST);
        put_request(MODE_REQUEST, SIZE_W'(100));
        put_request(MODE_REQUEST, SIZE_W'(60));
        put_request(MODE_REQUEST, '0);

        set_policy(POL_WORST);
        put_request(MODE_REQUEST, SIZE_W'(1));
        put_request(MODE_REQUEST, {SIZE_W{1'b1}});

        set_policy(2'd3);
        put_request(MODE_REQUEST, '0);
        put_request(MODE_RESTORE, '0);
        put_request(MODE_REQUEST, SIZE_W'(5));

        set_policy(POL_FIRST);
        put_request(2'd3, '0);

        for (ph = 0; ph < N_PHASES; ph++) begin
            set_policy(ph < 4 ? ph[1:0] : 2'($urandom_range(0, 3)));
            quiet = (ph == 5);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(99);
                if (loads_sent < MAX_BLOCKS + 8 && r < 45) begin
                    put_request(MODE_LOAD, pick_block_size());
                end else if (r < 3) begin
                    raw = $urandom;
                    put_request(2'd3, raw[SIZE_W-1:0]);
                end else if (r < 6) begin
                    put_request(MODE_RESTORE, '0);
                end else if (r < 9 && loads_sent >= MAX_BLOCKS + 8) begin
                    put_request(MODE_LOAD, pick_block_size());
                end else begin
                    put_request(MODE_REQUEST, pick_need());
                end
            end
        end
        quiet = 1'b0;

        drain_results();
        if (alloc_fails == 0 && alloc_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
